// ===== sv/anchored_substring_match_macros.svh =====
// Assertion macros shared by the matcher checker.
// Depends on signals named clock and reset in the module that uses them.
`ifndef ANCHORED_SUBSTRING_MATCH_MACROS_SVH
`define ANCHORED_SUBSTRING_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is high.
`define ASM_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/asm_pkg.sv =====
// Shared types and constants for the anchored substring matcher.
// No dependencies; used by the cell, the top level and the checker.
`timescale 1ns / 1ps

package asm_pkg;

   // Default number of pattern cells.
   localparam int MAX_PATTERN_DEF = 64;

   // Special pattern bytes.
   localparam logic [7:0] CARET     = 8'h5E;
   localparam logic [7:0] BACKSLASH = 8'h5C;

   // Line counter width and saturation value.
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Input operation codes; the fourth code is ignored.
   typedef enum logic [1:0] {
      OP_PATTERN = 2'd0,
      OP_LINE    = 2'd1,
      OP_EOL     = 2'd2
   } op_type;

   // Controls broadcast from the top level to every cell.
   typedef struct packed {
      logic       shift;       // advance partial matches by one line byte
      logic       clear;       // drop all partial matches
      logic       write;       // store data into the selected cell
      logic       clear_last;  // forget which cell holds the last pattern byte
      logic [7:0] data;        // line or pattern byte
   } cell_ctl_type;

   // One result item.
   typedef struct packed {
      logic               matched;
      logic               pattern_error;
      logic [COUNT_W-1:0] match_count;
   } rsp_type;

endpackage

// ===== sv/asm_cell.sv =====
// One shift-and cell: a pattern byte, its partial-match bit and its last-byte flag.
// Depends on asm_pkg for the control struct.
`timescale 1ns / 1ps

module asm_cell #(
   parameter int IDX_W = 7,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  asm_pkg::cell_ctl_type ctl,
   input  logic [IDX_W-1:0]     wr_index,
   input  logic                 prev_match,
   output logic                 match,
   output logic                 hit
);
   import asm_pkg::*;

   logic [7:0] char_ff;
   logic [7:0] char_in;
   logic       match_ff;
   logic       match_in;
   logic       last_ff;
   logic       last_in;
   logic       selected;

   assign selected = ctl.write && (wr_index == IDX_W'(INDEX));

   // Next state of the stored byte, the match bit and the last flag.
   always_comb begin
      char_in = selected ? ctl.data : char_ff;

      if (ctl.clear) begin
         match_in = 1'b0;
      end else if (ctl.shift) begin
         match_in = prev_match && (char_ff == ctl.data);
      end else begin
         match_in = match_ff;
      end

      if (selected) begin
         last_in = 1'b1;
      end else if (ctl.write || ctl.clear_last) begin
         last_in = 1'b0;
      end else begin
         last_in = last_ff;
      end
   end

   // The pattern byte needs no reset; the control bits do.
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      if (reset) begin
         match_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         match_ff <= match_in;
         last_ff  <= last_in;
      end
   end

   assign match = match_ff;
   // A full match completes when the last pattern cell becomes set.
   assign hit   = match_in && last_ff;

endmodule

// ===== sv/anchored_substring_match.sv =====
// Anchored substring matcher: a row of MAX_PATTERN shift-and cells.
// Each accepted item updates the cell row registers; one item is accepted per cycle while req_ready is high.
// An end-of-line result is registered into the output buffer when its transfer is accepted.
// A two-entry output buffer absorbs one result while rsp_ready is low; req_ready drops
// only while both entries hold results.
// Synchronous reset empties the pattern (every line matches) and zeros the count.
`timescale 1ns / 1ps

module anchored_substring_match #(
   parameter int MAX_PATTERN = asm_pkg::MAX_PATTERN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [7:0]                  req_byte_value,
   input  logic                        req_pattern_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_matched,
   output logic                        rsp_pattern_error,
   output logic [asm_pkg::COUNT_W-1:0] rsp_match_count
);
   import asm_pkg::*;

   localparam int IDX_W = $clog2(MAX_PATTERN + 1);

   // Pattern and line state.
   logic [IDX_W-1:0]   len_ff,    len_in;
   logic               anch_ff,   anch_in;
   logic               esc_ff,    esc_in;
   logic               loading_ff, loading_in;
   logic               line_hit_ff, line_hit_in;
   logic               at_start_ff, at_start_in;
   logic [COUNT_W-1:0] count_ff,  count_in;

   // Output buffer: a head register and a skid register.
   logic    out_valid_ff,  out_valid_in;
   rsp_type out_ff,        out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff,       skid_in;

   logic             accept;
   op_type           op;
   logic             start;
   logic [IDX_W-1:0] len_eff;
   logic             anch_eff;
   logic             esc_eff;
   logic             room;
   logic             push;
   logic             eol_hit;
   rsp_type          result;
   cell_ctl_type     ctl;

   logic [MAX_PATTERN-1:0] match_vec;
   logic [MAX_PATTERN-1:0] hit_vec;
   logic                   first_prev;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign op        = op_type'(req_opcode);

   // A pattern byte outside a load starts a fresh pattern.
   assign start    = !loading_ff;
   assign len_eff  = start ? '0 : len_ff;
   assign anch_eff = start ? 1'b0 : anch_ff;
   assign esc_eff  = start ? 1'b0 : esc_ff;
   assign room     = len_eff < IDX_W'(MAX_PATTERN);

   // A match may begin anywhere unless anchored, then only at the line start.
   assign first_prev = !anch_ff || at_start_ff;

   // Line verdict and updated count for an end of line.
   assign eol_hit              = !esc_ff && ((len_ff == '0) || line_hit_ff);
   assign result.matched       = eol_hit;
   assign result.pattern_error = esc_ff;
   assign result.match_count   = (eol_hit && (count_ff != COUNT_MAX)) ?
                                 count_ff + COUNT_W'(1) : count_ff;

   // Pattern load, line scan and end-of-line control.
   always_comb begin
      len_in      = len_ff;
      anch_in     = anch_ff;
      esc_in      = esc_ff;
      loading_in  = loading_ff;
      at_start_in = at_start_ff;
      count_in    = count_ff;
      ctl         = '0;
      ctl.data    = req_byte_value;
      push        = 1'b0;

      if (accept) begin
         unique case (op)
            OP_PATTERN: begin
               ctl.clear      = 1'b1;
               ctl.clear_last = start;
               at_start_in    = 1'b1;
               loading_in     = !req_pattern_last;
               len_in         = len_eff;
               anch_in        = anch_eff;
               esc_in         = esc_eff;
               if (esc_eff) begin
                  esc_in    = 1'b0;
                  ctl.write = room;
               end else if (req_byte_value == BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (req_byte_value == CARET && len_eff == '0 && !anch_eff) begin
                  anch_in = 1'b1;
               end else begin
                  ctl.write = room;
               end
               if (ctl.write) begin
                  len_in = len_eff + IDX_W'(1);
               end
            end
            OP_LINE: begin
               loading_in  = 1'b0;
               ctl.shift   = 1'b1;
               at_start_in = 1'b0;
            end
            OP_EOL: begin
               loading_in  = 1'b0;
               ctl.clear   = 1'b1;
               at_start_in = 1'b1;
               count_in    = result.match_count;
               push        = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Line hit flag: set when the last pattern cell completes, dropped on an end of line or a pattern byte.
   always_comb begin
      line_hit_in = line_hit_ff;
      if (accept && (op == OP_LINE) && (|hit_vec)) begin
         line_hit_in = 1'b1;
      end else if (accept && (op inside {OP_PATTERN, OP_EOL})) begin
         line_hit_in = 1'b0;
      end
   end

   // Output buffer next state: skid refills the head when the head drains.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (out_valid_ff) begin
         if (push) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (push) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         len_ff        <= '0;
         anch_ff       <= 1'b0;
         esc_ff        <= 1'b0;
         loading_ff    <= 1'b0;
         line_hit_ff   <= 1'b0;
         at_start_ff   <= 1'b1;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         anch_ff       <= anch_in;
         esc_ff        <= esc_in;
         loading_ff    <= loading_in;
         line_hit_ff   <= line_hit_in;
         at_start_ff   <= at_start_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // The cell row; each cell after the first takes its left neighbor's match bit, the first takes first_prev.
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic prev;
      if (i == 0) begin : g_first
         assign prev = first_prev;
      end else begin : g_rest
         assign prev = match_vec[i-1];
      end
      asm_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_index   (len_eff),
         .prev_match (prev),
         .match      (match_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_matched       = out_ff.matched;
   assign rsp_pattern_error = out_ff.pattern_error;
   assign rsp_match_count   = out_ff.match_count;

endmodule

// ===== sv/asm_checker.sv =====
// Port-level checker for the anchored substring matcher, bound to the top level.
// Depends on asm_pkg and anchored_substring_match_macros.svh.
`timescale 1ns / 1ps

`include "anchored_substring_match_macros.svh"

module asm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [1:0]                  req_opcode,
   input logic [7:0]                  req_byte_value,
   input logic                        req_pattern_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_matched,
   input logic                        rsp_pattern_error,
   input logic [asm_pkg::COUNT_W-1:0] rsp_match_count
);
   import asm_pkg::*;

   // A stalled result transfer keeps its payload.
   `ASM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_matched) && $stable(rsp_pattern_error) && $stable(rsp_match_count), "result changed while stalled")

   // A malformed pattern never reports a match.
   `ASM_ASSERT_NOW(a_error_no_match, rsp_valid && rsp_pattern_error, !rsp_matched, "match reported with pattern error")

   // A matching line has been counted, so the count cannot be zero.
   `ASM_ASSERT_NOW(a_match_counted, rsp_valid && rsp_matched, rsp_match_count != '0, "match with zero count")

   // Reset leaves the output empty and the input open.
   `ASM_ASSERT_AFTER_RESET(a_reset_state, req_ready && !rsp_valid, "bad state after reset")

endmodule

bind anchored_substring_match asm_checker u_asm_checker (.*);
